/* src/bgpr_pkg.sv */
// ----------------------------------------------------------------------------
// bgpr_pkg: shared types and constants of the bitmap glyph pixel renderer
// Glyph geometry, store size, field widths, command and register codes, and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bgpr_pkg;

    // Glyph geometry and store size.
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 8;
    localparam int STORE_BYTES  = 2048;

    localparam int GLYPH_BITS  = GLYPH_WIDTH * GLYPH_HEIGHT;
    localparam int GLYPH_BYTES = (GLYPH_BITS + 7) / 8;

    // Field widths fixed by the interface.
    localparam int CMD_W     = 1;
    localparam int ADDR_W    = 11;
    localparam int BYTE_W    = 8;
    localparam int COORD_W   = 12;
    localparam int CODE_W    = 8;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    // Derived widths.
    localparam int GX_W     = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
    localparam int GY_W     = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
    localparam int BIT_W    = (GLYPH_BITS > 1) ? $clog2(GLYPH_BITS) : 1;
    localparam int GB_W     = (GLYPH_BYTES > 1) ? $clog2(GLYPH_BYTES) : 1;
    localparam int STORE_AW = $clog2(STORE_BYTES);
    // Wide enough for any glyph byte address and for STORE_BYTES itself.
    localparam int FULL_AW  = (CODE_W + GB_W + 1 > STORE_AW + 1) ?
                              (CODE_W + GB_W + 1) : (STORE_AW + 1);

    // Item commands.
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DRAW = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ASCII_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = 1'b1;

    // Register reset values.
    localparam logic [CFG_W-1:0] ASCII_BASE_RESET  = 8'd32;
    localparam logic [CFG_W-1:0] GLYPH_COUNT_RESET = 8'd255;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // write the item's byte into the glyph store
        logic start_draw;  // latch the draw item and clear the walk counters
        logic fetch;       // read the next glyph byte from the store
        logic walk_step;   // examine one glyph position, emit if set
        logic emit_empty;  // emit the lone result of an empty glyph
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;    // the offered draw item indexes a valid glyph
        logic fetch_done;  // the final glyph byte is being fetched
        logic bits_zero;   // no set bit remains in the glyph register
        logic step_last;   // the current position holds the final set bit
        logic out_free;    // the output register can take a result
    } t_dp_sts;

endpackage

/* src/bgpr_ctrl.sv */
// ----------------------------------------------------------------------------
// bgpr_ctrl: controller of the bitmap glyph pixel renderer
// Accepts items, sequences the glyph fetch and the column-major walk, and
// drives the datapath through a command bundle.
// ----------------------------------------------------------------------------
module bgpr_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [bgpr_pkg::CMD_W-1:0]     i_cmd,
    output logic                           o_in_stall,
    input  bgpr_pkg::t_dp_sts              i_sts,
    output bgpr_pkg::t_dp_cmd              o_dp_cmd
);
    import bgpr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LAND,
        ST_WALK
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_in_stall;
    logic    n_in_stall;
    t_dp_cmd dp_cmd;

    always_comb begin
        n_state = r_state;
        dp_cmd  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == CMD_LOAD) begin
                        dp_cmd.load = 1'b1;
                    end else if (i_sts.in_range) begin
                        dp_cmd.start_draw = 1'b1;
                        n_state           = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                dp_cmd.fetch = 1'b1;
                if (i_sts.fetch_done) begin
                    n_state = ST_LAND;
                end
            end
            ST_LAND: begin
                // The final glyph byte settles into the glyph register.
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (i_sts.out_free) begin
                    if (i_sts.bits_zero) begin
                        dp_cmd.emit_empty = 1'b1;
                        n_state           = ST_IDLE;
                    end else begin
                        dp_cmd.walk_step = 1'b1;
                        if (i_sts.step_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_in_stall = (n_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_in_stall = r_in_stall;
    assign o_dp_cmd   = dp_cmd;

`ifndef SYNTHESIS
    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input not stalled while a draw is in progress");

    a_land_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LAND) |-> ($past(r_state) == ST_FETCH))
        else $error("landing cycle not preceded by a fetch");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.walk_step || dp_cmd.emit_empty) |-> i_sts.out_free)
        else $error("result issued while the output register is occupied");
`endif

endmodule

/* src/bgpr_datapath.sv */
// ----------------------------------------------------------------------------
// bgpr_datapath: datapath of the bitmap glyph pixel renderer
// Holds the glyph store, the configuration registers, the fetched glyph,
// the walk counters and the output register.
// ----------------------------------------------------------------------------
module bgpr_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bgpr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bgpr_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [bgpr_pkg::ADDR_W-1:0]      i_store_address,
    input  logic [bgpr_pkg::BYTE_W-1:0]      i_store_byte,
    input  logic [bgpr_pkg::COORD_W-1:0]     i_origin_x,
    input  logic [bgpr_pkg::COORD_W-1:0]     i_origin_y,
    input  logic [bgpr_pkg::CODE_W-1:0]      i_char_code,
    input  logic [bgpr_pkg::COLOR_W-1:0]     i_ink_color,
    input  bgpr_pkg::t_dp_cmd                i_dp_cmd,
    output bgpr_pkg::t_dp_sts                o_sts,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic                             o_pixel_valid,
    output logic [bgpr_pkg::COORD_W-1:0]     o_pixel_x,
    output logic [bgpr_pkg::COORD_W-1:0]     o_pixel_y,
    output logic [bgpr_pkg::COLOR_W-1:0]     o_pixel_color,
    output logic [bgpr_pkg::COORD_W-1:0]     o_region_x,
    output logic [bgpr_pkg::COORD_W-1:0]     o_region_y,
    output logic                             o_last
);
    import bgpr_pkg::*;

    localparam logic [GX_W-1:0] GX_LAST = GX_W'(GLYPH_WIDTH - 1);
    localparam logic [GY_W-1:0] GY_LAST = GY_W'(GLYPH_HEIGHT - 1);
    localparam logic [GB_W-1:0] GB_LAST = GB_W'(GLYPH_BYTES - 1);

    // Configuration registers.
    logic [CFG_W-1:0] r_ascii_base;
    logic [CFG_W-1:0] r_glyph_count;

    // Glyph store.
    logic [BYTE_W-1:0] r_mem [STORE_BYTES];
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_zero;
    logic              r_fill_en;
    logic [GB_W-1:0]   r_fill_k;

    // Latched draw item.
    logic [COORD_W-1:0]  r_ox;
    logic [COORD_W-1:0]  r_oy;
    logic [COLOR_W-1:0]  r_color;
    logic [FULL_AW-1:0]  r_base_addr;

    // Fetch counter, glyph bits and walk position.
    logic [GB_W-1:0]       r_k;
    logic [GLYPH_BITS-1:0] r_bits;
    logic [GX_W-1:0]       r_gx;
    logic [GY_W-1:0]       r_gy;

    // Output register.
    logic               r_out_valid;
    logic               r_pixel_valid;
    logic [COORD_W-1:0] r_pixel_x;
    logic [COORD_W-1:0] r_pixel_y;
    logic [COLOR_W-1:0] r_pixel_color;
    logic [COORD_W-1:0] r_region_x;
    logic [COORD_W-1:0] r_region_y;
    logic               r_last;

    logic [CODE_W-1:0]     glyph_index;
    logic [FULL_AW-1:0]    rd_addr;
    logic                  wr_in_store;
    logic [BYTE_W-1:0]     fill_byte;
    logic [BIT_W-1:0]      bit_idx;
    logic                  cur_bit;
    logic [GLYPH_BITS-1:0] remaining;
    logic                  emit_pixel;
    logic                  emit;
    logic                  out_free;

    assign glyph_index = i_char_code - r_ascii_base;
    assign rd_addr     = r_base_addr + FULL_AW'(r_k);
    assign wr_in_store = (FULL_AW'(i_store_address) < FULL_AW'(STORE_BYTES));
    assign fill_byte   = r_rd_zero ? '0 : r_rd_data;
    assign bit_idx     = BIT_W'(BIT_W'(r_gy) * BIT_W'(GLYPH_WIDTH) + BIT_W'(r_gx));
    assign cur_bit     = r_bits[bit_idx];
    assign remaining   = r_bits & ~(GLYPH_BITS'(1) << bit_idx);
    assign emit_pixel  = i_dp_cmd.walk_step && cur_bit;
    assign emit        = emit_pixel || i_dp_cmd.emit_empty;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts            = '0;
        o_sts.in_range   = (i_char_code >= r_ascii_base) && (glyph_index < r_glyph_count);
        o_sts.fetch_done = (r_k == GB_LAST);
        o_sts.bits_zero  = (r_bits == '0);
        o_sts.step_last  = cur_bit && (remaining == '0);
        o_sts.out_free   = out_free;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascii_base  <= ASCII_BASE_RESET;
            r_glyph_count <= GLYPH_COUNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ASCII_BASE) begin
                r_ascii_base <= i_cfg_data;
            end else if (i_cfg_idx == CFG_GLYPH_COUNT) begin
                r_glyph_count <= i_cfg_data;
            end
        end
    end

    // Glyph store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load && wr_in_store) begin
            r_mem[STORE_AW'(i_store_address)] <= i_store_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.fetch) begin
            r_rd_data <= r_mem[STORE_AW'(rd_addr)];
            r_rd_zero <= !(rd_addr < FULL_AW'(STORE_BYTES));
            r_fill_k  <= r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_en <= 1'b0;
        end else begin
            r_fill_en <= i_dp_cmd.fetch;
        end
    end

    // Draw item, fetch counter and walk counters.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start_draw) begin
            r_ox        <= i_origin_x;
            r_oy        <= i_origin_y;
            r_color     <= i_ink_color;
            r_base_addr <= FULL_AW'(FULL_AW'(glyph_index) * FULL_AW'(GLYPH_BYTES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start_draw) begin
            r_k  <= '0;
            r_gx <= '0;
            r_gy <= '0;
        end else begin
            if (i_dp_cmd.fetch) begin
                r_k <= GB_W'(r_k + 1'b1);
            end
            if (i_dp_cmd.walk_step) begin
                if (r_gy == GY_LAST) begin
                    r_gy <= '0;
                    r_gx <= GX_W'(r_gx + 1'b1);
                end else begin
                    r_gy <= GY_W'(r_gy + 1'b1);
                end
            end
        end
    end

    // Glyph bits: filled one byte at a time, cleared as the walk passes.
    always_ff @(posedge i_clk) begin
        if (r_fill_en) begin
            for (int b = 0; b < GLYPH_BITS; b++) begin
                if (GB_W'(b >> 3) == r_fill_k) begin
                    r_bits[b] <= fill_byte[3'(b)];
                end
            end
        end else if (i_dp_cmd.walk_step) begin
            r_bits[bit_idx] <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_pixel) begin
            r_pixel_valid <= 1'b1;
            r_pixel_x     <= r_ox + COORD_W'(r_gx);
            r_pixel_y     <= r_oy + COORD_W'(r_gy);
            r_pixel_color <= r_color;
            r_region_x    <= r_ox;
            r_region_y    <= r_oy;
            r_last        <= (remaining == '0);
        end else if (i_dp_cmd.emit_empty) begin
            r_pixel_valid <= 1'b0;
            r_pixel_x     <= '0;
            r_pixel_y     <= '0;
            r_pixel_color <= '0;
            r_region_x    <= r_ox;
            r_region_y    <= r_oy;
            r_last        <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_valid = r_pixel_valid;
    assign o_pixel_x     = r_pixel_x;
    assign o_pixel_y     = r_pixel_y;
    assign o_pixel_color = r_pixel_color;
    assign o_region_x    = r_region_x;
    assign o_region_y    = r_region_y;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !emit)
        else $error("waiting result overwritten");

    a_walk_in_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.walk_step |-> (r_gx <= GX_LAST))
        else $error("walk ran past the last glyph column");

    a_fill_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_en |-> $past(i_dp_cmd.fetch))
        else $error("glyph byte landed without a fetch");
`endif

endmodule

/* src/bitmap_glyph_pixel_renderer.sv */
// ----------------------------------------------------------------------------
// bitmap_glyph_pixel_renderer: bit-packed font character generator
// Loads glyph bytes into an internal store and turns draw items into a
// column-major stream of pixel writes for the set bits of one glyph.
// ----------------------------------------------------------------------------
// Usage. The input channel (i_in_valid / o_in_stall) carries items. A load
// item (cmd 0) writes one glyph store byte in the cycle it is accepted and
// gives no result. A draw item (cmd 1) subtracts the ascii_base register from
// the character code; an index below zero or at or above glyph_count gives no
// result. Otherwise the block reads the glyph's bytes from the store, one per
// cycle through its single registered read port, lets the last byte land in
// the glyph register, and then walks the glyph one position per cycle while
// the output is free, column by column, giving one pixel write per set bit.
// The last pixel write carries last; an empty glyph gives one result with
// pixel_valid low and last high. A draw keeps the input stalled until the
// walk reaches its final set bit or the empty result is issued, and longer
// while the output is stalled. A stalled output holds its result and the walk
// pauses; the next item is taken while the final result still waits.
// Reset restores ascii_base to 32 and glyph_count to 255 and empties the
// output register; the store contents are undefined until written.
// ----------------------------------------------------------------------------
module bitmap_glyph_pixel_renderer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [bgpr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bgpr_pkg::CFG_W-1:0]       i_cfg_data,
    // Input item channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [bgpr_pkg::CMD_W-1:0]       i_cmd,
    input  logic [bgpr_pkg::ADDR_W-1:0]      i_store_address,
    input  logic [bgpr_pkg::BYTE_W-1:0]      i_store_byte,
    input  logic [bgpr_pkg::COORD_W-1:0]     i_origin_x,
    input  logic [bgpr_pkg::COORD_W-1:0]     i_origin_y,
    input  logic [bgpr_pkg::CODE_W-1:0]      i_char_code,
    input  logic [bgpr_pkg::COLOR_W-1:0]     i_ink_color,
    // Result item channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_pixel_valid,
    output logic [bgpr_pkg::COORD_W-1:0]     o_pixel_x,
    output logic [bgpr_pkg::COORD_W-1:0]     o_pixel_y,
    output logic [bgpr_pkg::COLOR_W-1:0]     o_pixel_color,
    output logic [bgpr_pkg::COORD_W-1:0]     o_region_x,
    output logic [bgpr_pkg::COORD_W-1:0]     o_region_y,
    output logic                             o_last
);
    import bgpr_pkg::*;

    // The controller decides what happens each cycle; the datapath answers
    // with status on the offered item, the fetch and the walk.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    bgpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_dp_cmd   (dp_cmd)
    );

    // The datapath owns the store, the configuration registers and the
    // output register, so the final result of a draw can wait there while
    // the controller already takes the next item.
    bgpr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_store_address (i_store_address),
        .i_store_byte    (i_store_byte),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_char_code     (i_char_code),
        .i_ink_color     (i_ink_color),
        .i_dp_cmd        (dp_cmd),
        .o_sts           (dp_sts),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_pixel_valid   (o_pixel_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_color   (o_pixel_color),
        .o_region_x      (o_region_x),
        .o_region_y      (o_region_y),
        .o_last          (o_last)
    );

endmodule
